@@ sv/oir_pkg.sv @@
// ----------------------------------------------------------------------------
// oir_pkg
// Shared types and constants of the image download receiver.
// ----------------------------------------------------------------------------
package oir_pkg;

    localparam int MaxContent = 32;
    localparam int AddrBits   = 24;
    localparam int BufDepth   = MaxContent + 1;
    localparam int BufIdxW    = $clog2(BufDepth);
    localparam int CntW       = $clog2(MaxContent + 1);

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_PKG   = 2'd2;
    localparam logic [1:0] REQ_ERASE = 2'd3;

    localparam logic [2:0] K_WRITE      = 3'd0;
    localparam logic [2:0] K_ERASE      = 3'd1;
    localparam logic [2:0] K_START_RSP  = 3'd2;
    localparam logic [2:0] K_ERASE_DONE = 3'd3;
    localparam logic [2:0] K_DATA_ACK   = 3'd4;
    localparam logic [2:0] K_PKG_ACK    = 3'd5;
    localparam logic [2:0] K_ERS_ACK    = 3'd6;
    localparam logic [2:0] K_READY      = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RESEND = 2'd1;
    localparam logic [1:0] ST_FAIL   = 2'd2;

    localparam logic [1:0] CFG_FLAG = 2'd0;
    localparam logic [1:0] CFG_BASE = 2'd1;
    localparam logic [1:0] CFG_MAXR = 2'd2;
    localparam logic [1:0] CFG_MINF = 2'd3;

    localparam logic [7:0] KEY_PKG   = 8'h0E;
    localparam logic [7:0] KEY_ERASE = 8'h09;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_FLAG,        // write of zero to the ready flag
        OP_START_FAIL,
        OP_START_OK,
        OP_ERASE,       // erase, also begins the download
        OP_ERASE_DONE,
        OP_BAD,         // bad packet ack
        OP_WRITE,       // one content write
        OP_FINISH,      // fold one pad byte
        OP_DATA_ACK,
        OP_LAST_ACK,
        OP_READY,
        OP_PKG_ACK,
        OP_ERS_ACK
    } t_op;

    typedef struct packed {
        logic       op_valid;
        t_op        op;
        logic       last;
        logic       status_fail;   // retry acks: key mismatch
        logic       clr_frame;
    } t_cmd;

    typedef struct packed {
        logic        receiving;
        logic        len_bad;
        logic        seq_bad;
        logic        chk_bad;
        logic        len_oob;
        logic        abort;        // next bad packet reaches the limit
        logic        more;
        logic        check_ok;
        logic        pad_done;
        logic        writes_done;
        logic [1:0]  req_type;
        logic        key_pkg;
        logic        key_erase;
        logic        out_busy;
    } t_sts;

endpackage

@@ sv/ota_image_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// ota_image_receiver_unit
// Image download receiver: frames in, store commands and responses out.
// ----------------------------------------------------------------------------
// Bytes that do not end a frame are taken one per cycle. After a frame end the
// input is held while the sequencer decodes the frame and issues its results
// one per cycle while the output is not stalled. A data packet is handled as a
// decode step, one write per content byte, one step to leave the write loop and
// the ack. The last packet adds up to three pad steps for the file check, one
// step to leave the pad loop and, when the check holds, the ready result. A
// good start frame issues the flag write, the start response, the erase and the
// erase-done result; a bad one ends after the start response. A retry frame
// issues its ack, after an erase when a package retry restarts the download;
// a bad packet issues only its ack. The output is registered, and the
// sequencer stalls while a result waits.
module ota_image_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_byte_value,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [23:0] o_address,
    output logic [7:0]  o_data_byte,
    output logic [23:0] o_length,
    output logic [15:0] o_seq_number,
    output logic [1:0]  o_status,
    output logic [31:0] o_image_check,
    output logic        o_last
);
    oir_pkg::t_cmd cmd;
    oir_pkg::t_sts sts;

    oir_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_frame_end(i_frame_end), .o_ready(o_ready), .i_sts(sts), .o_cmd(cmd)
    );

    oir_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_byte_take(i_valid && o_ready), .i_req_type(i_req_type),
        .i_byte_value(i_byte_value), .i_frame_end(i_frame_end),
        .i_cmd(cmd), .o_sts(sts), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_address(o_address), .o_data_byte(o_data_byte),
        .o_length(o_length), .o_seq_number(o_seq_number), .o_status(o_status),
        .o_image_check(o_image_check), .o_last(o_last)
    );
endmodule

@@ sv/oir_ram.sv @@
// ----------------------------------------------------------------------------
// oir_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oir_ram #(
    parameter int Width = 8,
    parameter int Depth = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/oir_datapath.sv @@
// ----------------------------------------------------------------------------
// oir_datapath
// Frame capture, session registers, content buffer and the output register.
// ----------------------------------------------------------------------------
module oir_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    input  logic                  i_byte_take,
    input  logic [1:0]            i_req_type,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_frame_end,
    input  oir_pkg::t_cmd         i_cmd,
    output oir_pkg::t_sts         o_sts,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_kind,
    output logic [23:0]           o_address,
    output logic [7:0]            o_data_byte,
    output logic [23:0]           o_length,
    output logic [15:0]           o_seq_number,
    output logic [1:0]            o_status,
    output logic [31:0]           o_image_check,
    output logic                  o_last
);
    localparam int AW = oir_pkg::AddrBits;

    logic [23:0] r_flag, r_base;
    logic [7:0]  r_maxr;
    logic [5:0]  r_minf;

    logic        r_recv;
    logic [23:0] r_img_len, r_bytes;
    logic [31:0] r_exp_chk, r_xor, r_pword;
    logic [AW-1:0] r_wptr;
    logic [15:0] r_next_seq;
    logic [7:0]  r_tally;
    logic [1:0]  r_pbytes;
    logic [15:0] r_pos;
    logic [7:0]  r_pxor, r_chk;
    logic [31:0] r_hwa, r_hwb;
    logic [1:0]  r_type;
    logic [oir_pkg::CntW-1:0] r_valid_cnt, r_widx;

    logic [7:0]  rd_byte;
    logic        buf_we;
    logic [oir_pkg::BufIdxW-1:0] buf_waddr;
    logic [15:0] pos_m7;

    assign pos_m7    = r_pos - 16'd7;
    assign buf_we    = i_byte_take && r_pos >= 16'd7
                       && pos_m7 < 16'(oir_pkg::BufDepth);
    assign buf_waddr = pos_m7[oir_pkg::BufIdxW-1:0];

    // Read address runs one ahead of the write index so data is ready.
    logic [oir_pkg::CntW-1:0] rd_idx;
    assign rd_idx = (i_cmd.op_valid && i_cmd.op == oir_pkg::OP_WRITE)
                    ? r_widx + 1'b1 : r_widx;

    oir_ram #(.Width(8), .Depth(oir_pkg::BufDepth)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (i_byte_value),
        .i_raddr (oir_pkg::BufIdxW'(rd_idx)),
        .o_rdata (rd_byte)
    );

    // Frame length as the model counts it: position of the end byte plus one.
    logic [16:0] flen;
    logic [23:0] remaining, clen24;
    logic [31:0] hdr_len;
    logic [7:0]  tally_inc;
    logic [7:0]  lo;
    assign flen      = {1'b0, r_pos} + 17'd1;
    assign hdr_len   = r_hwa;
    assign remaining = (r_bytes < r_img_len) ? r_img_len - r_bytes : 24'd0;
    assign clen24    = 24'(flen) - 24'd8;
    assign tally_inc = (r_tally == 8'hFF) ? r_tally : r_tally + 8'd1;
    assign lo        = (r_minf < 6'd8) ? 8'd8 : {2'b0, r_minf};

    logic [31:0] fold_word;
    logic [7:0]  fold_byte;
    assign fold_byte = (i_cmd.op == oir_pkg::OP_FINISH) ? 8'hFF : rd_byte;
    assign fold_word = r_pword | ({24'd0, fold_byte} << {r_pbytes, 3'b000});

    always_comb begin
        o_sts             = '0;
        o_sts.receiving   = r_recv;
        o_sts.len_bad     = hdr_len == 32'd0 || hdr_len > {8'd0, r_flag};
        o_sts.len_oob     = flen < {9'd0, lo} || flen > 17'(oir_pkg::MaxContent + 8);
        o_sts.seq_bad     = r_hwa[15:0] != r_next_seq;
        o_sts.chk_bad     = r_pxor != r_chk;
        o_sts.abort       = tally_inc >= r_maxr;
        o_sts.more        = r_hwa[23:16] != 8'd0;
        o_sts.check_ok    = r_xor == r_exp_chk;
        o_sts.pad_done    = r_pbytes == 2'd0;
        o_sts.writes_done = r_widx == r_valid_cnt;
        o_sts.req_type    = r_type;
        o_sts.key_pkg     = r_hwa[7:0] == oir_pkg::KEY_PKG;
        o_sts.key_erase   = r_hwa[7:0] == oir_pkg::KEY_ERASE;
        o_sts.out_busy    = o_valid && !i_ready;
    end

    logic clear_session;
    logic begin_dl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 24'd65280; r_base <= '0; r_maxr <= 8'd10; r_minf <= 6'd9;
            r_recv <= 1'b0; r_img_len <= '0; r_bytes <= '0; r_exp_chk <= '0;
            r_xor <= '0; r_pword <= '0; r_wptr <= '0; r_next_seq <= '0;
            r_tally <= '0; r_pbytes <= '0; r_pos <= '0; r_pxor <= '0;
            r_hwa <= '0; r_hwb <= '0; r_chk <= '0; r_type <= '0;
            r_valid_cnt <= '0; r_widx <= '0; o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    oir_pkg::CFG_FLAG: r_flag <= i_cfg_data;
                    oir_pkg::CFG_BASE: r_base <= i_cfg_data;
                    oir_pkg::CFG_MAXR: r_maxr <= i_cfg_data[7:0];
                    oir_pkg::CFG_MINF: r_minf <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (i_byte_take) begin
                if (r_pos >= 16'd4 && r_pos <= 16'd7) begin
                    r_hwa <= r_hwa | ({24'd0, i_byte_value} << {r_pos[1:0], 3'b000});
                end else if (r_pos >= 16'd8 && r_pos <= 16'd11) begin
                    r_hwb <= r_hwb | ({24'd0, i_byte_value} << {r_pos[1:0], 3'b000});
                end
                if (!i_frame_end) begin
                    if (r_pos >= 16'd7) r_pxor <= r_pxor ^ i_byte_value;
                    if (r_pos != 16'hFFFF) r_pos <= r_pos + 16'd1;
                end else begin
                    r_chk  <= i_byte_value;
                    r_type <= i_req_type;
                    // Content count for a good data frame, clamped to the file.
                    if ({7'd0, clen24[16:0]} <= remaining)
                        r_valid_cnt <= oir_pkg::CntW'(clen24);
                    else
                        r_valid_cnt <= oir_pkg::CntW'(remaining);
                    r_widx <= '0;
                end
            end
            if (i_cmd.op_valid) begin
                o_valid       <= i_cmd.op != oir_pkg::OP_FINISH;
                o_kind        <= oir_pkg::K_WRITE;
                o_address     <= '0;
                o_data_byte   <= '0;
                o_length      <= '0;
                o_seq_number  <= '0;
                o_status      <= oir_pkg::ST_OK;
                o_image_check <= '0;
                o_last        <= i_cmd.last;
                case (i_cmd.op)
                    oir_pkg::OP_FLAG: o_address <= r_flag;
                    oir_pkg::OP_START_FAIL: begin
                        o_kind <= oir_pkg::K_START_RSP; o_status <= oir_pkg::ST_RESEND;
                    end
                    oir_pkg::OP_START_OK: begin
                        o_kind <= oir_pkg::K_START_RSP;
                        r_img_len <= hdr_len[23:0];
                        r_exp_chk <= r_hwb;
                    end
                    oir_pkg::OP_ERASE: begin
                        o_kind <= oir_pkg::K_ERASE; o_address <= r_base;
                        o_length <= r_img_len;
                    end
                    oir_pkg::OP_ERASE_DONE: o_kind <= oir_pkg::K_ERASE_DONE;
                    oir_pkg::OP_BAD: begin
                        o_kind <= oir_pkg::K_DATA_ACK;
                        o_seq_number <= o_sts.seq_bad ? r_hwa[15:0] : r_next_seq;
                        o_status <= o_sts.abort ? oir_pkg::ST_FAIL : oir_pkg::ST_RESEND;
                        r_tally <= tally_inc;
                    end
                    oir_pkg::OP_WRITE: begin
                        o_address   <= 24'(r_wptr + AW'(r_widx));
                        o_data_byte <= rd_byte;
                        r_widx      <= r_widx + 1'b1;
                    end
                    oir_pkg::OP_DATA_ACK, oir_pkg::OP_LAST_ACK: begin
                        o_kind <= oir_pkg::K_DATA_ACK;
                        o_seq_number <= r_hwa[15:0];
                        if (i_cmd.op == oir_pkg::OP_LAST_ACK && !o_sts.check_ok)
                            o_status <= oir_pkg::ST_FAIL;
                    end
                    oir_pkg::OP_READY: begin
                        o_kind <= oir_pkg::K_READY; o_address <= r_flag;
                        o_length <= r_img_len; o_image_check <= r_exp_chk;
                    end
                    oir_pkg::OP_PKG_ACK: begin
                        o_kind <= oir_pkg::K_PKG_ACK;
                        if (i_cmd.status_fail) o_status <= oir_pkg::ST_RESEND;
                    end
                    oir_pkg::OP_ERS_ACK: begin
                        o_kind <= oir_pkg::K_ERS_ACK;
                        if (i_cmd.status_fail) o_status <= oir_pkg::ST_RESEND;
                        else r_recv <= 1'b0;
                    end
                    default: ;
                endcase
                if (i_cmd.op == oir_pkg::OP_WRITE || i_cmd.op == oir_pkg::OP_FINISH) begin
                    if (r_pbytes == 2'd3) begin
                        r_xor <= r_xor ^ fold_word; r_pword <= '0;
                    end else begin
                        r_pword <= fold_word;
                    end
                    r_pbytes <= r_pbytes + 2'd1;
                end
                if (i_cmd.op == oir_pkg::OP_DATA_ACK
                    || i_cmd.op == oir_pkg::OP_LAST_ACK) begin
                    r_wptr     <= r_wptr + AW'(r_valid_cnt);
                    r_bytes    <= r_bytes + 24'(r_valid_cnt);
                    r_next_seq <= r_next_seq + 16'd1;
                    r_tally    <= '0;
                end
                if (begin_dl) begin
                    r_recv <= 1'b1; r_wptr <= r_base; r_next_seq <= '0;
                    r_bytes <= '0; r_tally <= '0; r_xor <= '0; r_pword <= '0;
                    r_pbytes <= '0;
                end
                if (clear_session) begin
                    r_recv <= 1'b0; r_img_len <= '0; r_exp_chk <= '0; r_wptr <= '0;
                    r_next_seq <= '0; r_bytes <= '0; r_tally <= '0; r_xor <= '0;
                    r_pword <= '0; r_pbytes <= '0;
                end
            end
            if (i_cmd.clr_frame) begin
                r_pos <= '0; r_pxor <= '0; r_hwa <= '0; r_hwb <= '0;
            end
        end
    end

    assign begin_dl = i_cmd.op == oir_pkg::OP_ERASE;
    assign clear_session = i_cmd.op == oir_pkg::OP_START_FAIL
        || (i_cmd.op == oir_pkg::OP_BAD && o_sts.abort)
        || ((i_cmd.op == oir_pkg::OP_LAST_ACK) && !o_sts.check_ok)
        || i_cmd.op == oir_pkg::OP_READY;
endmodule

@@ sv/oir_ctrl.sv @@
// ----------------------------------------------------------------------------
// oir_ctrl
// Sequencer that turns each frame end into a series of datapath operations.
// ----------------------------------------------------------------------------
module oir_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_frame_end,
    output logic          o_ready,
    input  oir_pkg::t_sts i_sts,
    output oir_pkg::t_cmd o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DISP   = 11'b00000000010,
        S_FLAG   = 11'b00000000100,
        S_SRSP   = 11'b00000001000,
        S_ERASE  = 11'b00000010000,
        S_EDONE  = 11'b00000100000,
        S_WRITE  = 11'b00001000000,
        S_PAD    = 11'b00010000000,
        S_ACK    = 11'b00100000000,
        S_READY  = 11'b01000000000,
        S_RETRY  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pkg;   // erase step came from a package retry

    assign o_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.op = oir_pkg::OP_NONE;
        case (r_state)
            S_IDLE: if (i_valid && i_frame_end) n_state = S_DISP;
            S_DISP: begin
                n_state = S_IDLE;
                o_cmd.clr_frame = 1'b1;
                case (i_sts.req_type)
                    oir_pkg::REQ_START: if (!i_sts.receiving) begin
                        o_cmd.clr_frame = 1'b0; n_state = S_FLAG;
                    end
                    oir_pkg::REQ_DATA:
                        if (i_sts.receiving && !i_sts.len_oob) begin
                            o_cmd.clr_frame = 1'b0;
                            n_state = (i_sts.seq_bad || i_sts.chk_bad) ? S_ACK : S_WRITE;
                        end
                    default: begin
                        o_cmd.clr_frame = 1'b0; n_state = S_RETRY;
                    end
                endcase
            end
            default: ;
        endcase
        if (!i_sts.out_busy) begin
            case (r_state)
                S_FLAG: begin
                    o_cmd.op_valid = 1'b1; o_cmd.op = oir_pkg::OP_FLAG;
                    n_state = S_SRSP;
                end
                S_SRSP: begin
                    o_cmd.op_valid = 1'b1;
                    if (i_sts.len_bad) begin
                        o_cmd.op = oir_pkg::OP_START_FAIL; o_cmd.last = 1'b1;
                        o_cmd.clr_frame = 1'b1; n_state = S_IDLE;
                    end else begin
                        o_cmd.op = oir_pkg::OP_START_OK; n_state = S_ERASE;
                    end
                end
                S_ERASE: begin
                    o_cmd.op_valid = 1'b1; o_cmd.op = oir_pkg::OP_ERASE;
                    n_state = r_pkg ? S_RETRY : S_EDONE;
                end
                S_EDONE: begin
                    o_cmd.op_valid = 1'b1; o_cmd.op = oir_pkg::OP_ERASE_DONE;
                    o_cmd.last = 1'b1; o_cmd.clr_frame = 1'b1; n_state = S_IDLE;
                end
                S_WRITE: if (i_sts.writes_done) begin
                    n_state = i_sts.more ? S_ACK : S_PAD;
                end else begin
                    o_cmd.op_valid = 1'b1; o_cmd.op = oir_pkg::OP_WRITE;
                end
                S_PAD: if (i_sts.pad_done) begin
                    n_state = S_ACK;
                end else begin
                    o_cmd.op_valid = 1'b1; o_cmd.op = oir_pkg::OP_FINISH;
                end
                S_ACK: begin
                    o_cmd.op_valid = 1'b1; o_cmd.clr_frame = 1'b1; n_state = S_IDLE;
                    o_cmd.last = 1'b1;
                    if (i_sts.seq_bad || i_sts.chk_bad) begin
                        o_cmd.op = oir_pkg::OP_BAD;
                    end else if (i_sts.more) begin
                        o_cmd.op = oir_pkg::OP_DATA_ACK;
                    end else begin
                        o_cmd.op = oir_pkg::OP_LAST_ACK;
                        if (i_sts.check_ok) begin
                            o_cmd.last = 1'b0; o_cmd.clr_frame = 1'b0;
                            n_state = S_READY;
                        end
                    end
                end
                S_READY: begin
                    o_cmd.op_valid = 1'b1; o_cmd.op = oir_pkg::OP_READY;
                    o_cmd.last = 1'b1; o_cmd.clr_frame = 1'b1; n_state = S_IDLE;
                end
                S_RETRY: begin
                    if (i_sts.req_type == oir_pkg::REQ_PKG && i_sts.key_pkg && !r_pkg) begin
                        n_state = S_ERASE;
                    end else begin
                        o_cmd.op_valid = 1'b1; o_cmd.last = 1'b1;
                        o_cmd.clr_frame = 1'b1; n_state = S_IDLE;
                        if (i_sts.req_type == oir_pkg::REQ_PKG) begin
                            o_cmd.op = oir_pkg::OP_PKG_ACK;
                            o_cmd.status_fail = !i_sts.key_pkg;
                        end else begin
                            o_cmd.op = oir_pkg::OP_ERS_ACK;
                            o_cmd.status_fail = !i_sts.key_erase;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pkg   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RETRY && n_state == S_ERASE) r_pkg <= 1'b1;
            else if (n_state == S_IDLE) r_pkg <= 1'b0;
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_cmd.op_valid) else $error("op issued while taking bytes");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op_valid && o_cmd.last) |=> r_state == S_IDLE)
        else $error("last result but sequence goes on");
endmodule

@@ bench/oir_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oir_checker
// Watches both channels of the image download receiver, predicts the results
// of every accepted request and compares them field by field in order.
// ----------------------------------------------------------------------------
module oir_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_byte_value,
    input  logic        i_frame_end,
    input  logic        i_valid_out,
    input  logic        i_ready,
    input  logic [2:0]  i_kind,
    input  logic [23:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic [23:0] i_length,
    input  logic [15:0] i_seq_number,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_image_check,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [7:0]  data_byte;
        logic [23:0] length;
        logic [15:0] seq_number;
        logic [1:0]  status;
        logic [31:0] image_check;
        logic        last;
    } t_result;

    t_result expected_results[$];

    logic [23:0] flag_addr, img_base;
    logic [7:0]  resend_limit;
    logic [5:0]  min_frame;

    logic        rx_active;
    logic [23:0] img_len, wr_ptr, rx_bytes;
    logic [31:0] want_check, word_xor, part_word, hdr_a, hdr_b;
    logic [15:0] seq_next, frame_pos;
    logic [7:0]  bad_count, frame_xor;
    logic [1:0]  part_cnt;
    logic [7:0]  content[0:oir_pkg::MaxContent];
    int          step_count;

    task automatic push_result(input logic [2:0] k, input logic [23:0] a,
                               input logic [7:0] d, input logic [23:0] l,
                               input logic [15:0] s, input logic [1:0] st,
                               input logic [31:0] c);
        t_result r;
        r = '{k, a, d, l, s, st, c, 1'b0};
        expected_results.push_back(r);
        step_count++;
    endtask

    task automatic clear_session();
        rx_active = 0; img_len = 0; want_check = 0; wr_ptr = 0; seq_next = 0;
        rx_bytes = 0; bad_count = 0; word_xor = 0; part_word = 0; part_cnt = 0;
    endtask

    task automatic begin_download();
        rx_active = 1; wr_ptr = img_base; seq_next = 0; rx_bytes = 0;
        bad_count = 0; word_xor = 0; part_word = 0; part_cnt = 0;
    endtask

    task automatic fold_byte(input logic [7:0] b);
        part_word = part_word | (32'(b) << (8 * part_cnt));
        if (part_cnt == 2'd3) begin
            word_xor  = word_xor ^ part_word;
            part_word = 0;
        end
        part_cnt = part_cnt + 2'd1;
    endtask

    task automatic bad_packet(input logic [15:0] s);
        if (bad_count != 8'hFF)
            bad_count = bad_count + 8'd1;
        if (bad_count >= resend_limit) begin
            push_result(oir_pkg::K_DATA_ACK, 0, 0, 0, s, oir_pkg::ST_FAIL, 0);
            clear_session();
        end else begin
            push_result(oir_pkg::K_DATA_ACK, 0, 0, 0, s, oir_pkg::ST_RESEND, 0);
        end
    endtask

    task automatic predict_data(input int flen, input logic [7:0] chk);
        int          lo, clen, valid;
        logic [15:0] s;
        logic [7:0]  more;
        logic [23:0] remaining;
        lo = (min_frame < 8) ? 8 : int'(min_frame);
        if (!rx_active || flen < lo || flen > oir_pkg::MaxContent + 8)
            return;
        s    = hdr_a[15:0];
        more = hdr_a[23:16];
        if (s != seq_next) begin
            bad_packet(s);
            return;
        end
        if (frame_xor != chk) begin
            bad_packet(seq_next);
            return;
        end
        clen      = flen - 8;
        remaining = (rx_bytes < img_len) ? img_len - rx_bytes : 24'd0;
        valid     = (clen <= int'(remaining)) ? clen : int'(remaining);
        for (int i = 0; i < valid; i++) begin
            push_result(oir_pkg::K_WRITE, wr_ptr + 24'(i), content[i], 0, 0,
                        oir_pkg::ST_OK, 0);
            fold_byte(content[i]);
        end
        wr_ptr   = wr_ptr + 24'(valid);
        rx_bytes = rx_bytes + 24'(valid);
        seq_next = seq_next + 16'd1;
        bad_count = 0;
        if (more == 0) begin
            while (part_cnt != 0)
                fold_byte(8'hFF);
            if (word_xor == want_check) begin
                push_result(oir_pkg::K_DATA_ACK, 0, 0, 0, s, oir_pkg::ST_OK, 0);
                push_result(oir_pkg::K_READY, flag_addr, 0, img_len, 0, oir_pkg::ST_OK,
                            want_check);
            end else begin
                push_result(oir_pkg::K_DATA_ACK, 0, 0, 0, s, oir_pkg::ST_FAIL, 0);
            end
            clear_session();
            return;
        end
        push_result(oir_pkg::K_DATA_ACK, 0, 0, 0, s, oir_pkg::ST_OK, 0);
    endtask

    task automatic predict_byte(input logic [1:0] rt, input logic [7:0] b,
                                input logic fe);
        int pos;
        pos = frame_pos;
        step_count = 0;
        if (pos >= 4 && pos <= 7)
            hdr_a = hdr_a | (32'(b) << (8 * (pos - 4)));
        else if (pos >= 8 && pos <= 11)
            hdr_b = hdr_b | (32'(b) << (8 * (pos - 8)));
        if (pos >= 7 && pos - 7 <= oir_pkg::MaxContent)
            content[pos - 7] = b;
        if (!fe) begin
            if (pos >= 7)
                frame_xor = frame_xor ^ b;
            if (frame_pos != 16'hFFFF)
                frame_pos = frame_pos + 16'd1;
            return;
        end
        case (rt)
            oir_pkg::REQ_START: begin
                if (!rx_active) begin
                    push_result(oir_pkg::K_WRITE, flag_addr, 0, 0, 0, oir_pkg::ST_OK, 0);
                    if (hdr_a == 0 || hdr_a > {8'd0, flag_addr}) begin
                        push_result(oir_pkg::K_START_RSP, 0, 0, 0, 0, oir_pkg::ST_RESEND, 0);
                        clear_session();
                    end else begin
                        img_len    = hdr_a[23:0];
                        want_check = hdr_b;
                        push_result(oir_pkg::K_START_RSP, 0, 0, 0, 0, oir_pkg::ST_OK, 0);
                        push_result(oir_pkg::K_ERASE, img_base, 0, img_len, 0,
                                    oir_pkg::ST_OK, 0);
                        begin_download();
                        push_result(oir_pkg::K_ERASE_DONE, 0, 0, 0, 0, oir_pkg::ST_OK, 0);
                    end
                end
            end
            oir_pkg::REQ_DATA: predict_data(pos + 1, b);
            oir_pkg::REQ_PKG: begin
                if (hdr_a[7:0] == oir_pkg::KEY_PKG) begin
                    push_result(oir_pkg::K_ERASE, img_base, 0, img_len, 0, oir_pkg::ST_OK, 0);
                    begin_download();
                    push_result(oir_pkg::K_PKG_ACK, 0, 0, 0, 0, oir_pkg::ST_OK, 0);
                end else begin
                    push_result(oir_pkg::K_PKG_ACK, 0, 0, 0, 0, oir_pkg::ST_RESEND, 0);
                end
            end
            default: begin
                if (hdr_a[7:0] == oir_pkg::KEY_ERASE) begin
                    rx_active = 0;
                    push_result(oir_pkg::K_ERS_ACK, 0, 0, 0, 0, oir_pkg::ST_OK, 0);
                end else begin
                    push_result(oir_pkg::K_ERS_ACK, 0, 0, 0, 0, oir_pkg::ST_RESEND, 0);
                end
            end
        endcase
        frame_pos = 0; frame_xor = 0; hdr_a = 0; hdr_b = 0;
        if (step_count > 0)
            expected_results[$].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            flag_addr = 24'd65280; img_base = 0; resend_limit = 8'd10;
            min_frame = 6'd9;
            clear_session();
            frame_pos = 0; frame_xor = 0; hdr_a = 0; hdr_b = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    oir_pkg::CFG_FLAG: flag_addr    = i_cfg_data;
                    oir_pkg::CFG_BASE: img_base     = i_cfg_data;
                    oir_pkg::CFG_MAXR: resend_limit = i_cfg_data[7:0];
                    oir_pkg::CFG_MINF: min_frame    = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in)
                predict_byte(i_req_type, i_byte_value, i_frame_end);
            if (i_valid_out && i_ready) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result kind", i_kind, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (i_kind != w.kind) report_mismatch("kind", i_kind, w.kind);
                    if (i_address != w.address)
                        report_mismatch("address", i_address, w.address);
                    if (i_data_byte != w.data_byte)
                        report_mismatch("data_byte", i_data_byte, w.data_byte);
                    if (i_length != w.length) report_mismatch("length", i_length, w.length);
                    if (i_seq_number != w.seq_number)
                        report_mismatch("seq_number", i_seq_number, w.seq_number);
                    if (i_status != w.status) report_mismatch("status", i_status, w.status);
                    if (i_image_check != w.image_check)
                        report_mismatch("image_check", i_image_check, w.image_check);
                    if (i_last != w.last) report_mismatch("last", i_last, w.last);
                end
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
    end

endmodule

@@ bench/tb_ota_image_receiver_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ota_image_receiver_unit
// Drives start, data and retry frames into the image download receiver under
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_ota_image_receiver_unit;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [23:0] i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_req_type = 0;
    logic [7:0]  i_byte_value = 0;
    logic        i_frame_end = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_kind;
    logic [23:0] o_address;
    logic [7:0]  o_data_byte;
    logic [23:0] o_length;
    logic [15:0] o_seq_number;
    logic [1:0]  o_status;
    logic [31:0] o_image_check;
    logic        o_last;

    int          error_count, pending_count, result_count;
    int          frame_count, byte_count, byte_budget;
    bit          calm;
    logic [7:0]  frame_bytes[$];
    logic [15:0] send_seq;
    logic [23:0] cur_flag;

    always #5 i_clk = ~i_clk;

    ota_image_receiver_unit dut (.*);

    oir_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid,
        .i_ready_in(o_ready), .i_req_type, .i_byte_value, .i_frame_end,
        .i_valid_out(o_valid), .i_ready, .i_kind(o_kind), .i_address(o_address),
        .i_data_byte(o_data_byte), .i_length(o_length),
        .i_seq_number(o_seq_number), .i_status(o_status),
        .i_image_check(o_image_check), .i_last(o_last),
        .o_errors(error_count), .o_pending(pending_count), .o_results(result_count)
    );

    // The result side stalls at random except during calm stretches.
    always @(posedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 19);

    task automatic send_frame(input logic [1:0] rt);
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) begin
            while (!calm && $urandom_range(99) < 19) begin
                i_valid <= 0;
                @(posedge i_clk);
            end
            i_valid      <= 1;
            i_req_type   <= (i == n - 1) ? rt : 2'($urandom);
            i_byte_value <= frame_bytes[i];
            i_frame_end  <= (i == n - 1);
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            byte_count++;
        end
        i_valid <= 0;
        frame_count++;
    endtask

    task automatic start_frame(input logic [31:0] len, input logic [31:0] chk,
                               input int n);
        frame_bytes.delete();
        for (int i = 0; i < n; i++) begin
            if (i >= 4 && i <= 7) frame_bytes.push_back(len[8*(i-4) +: 8]);
            else if (i >= 8 && i <= 11) frame_bytes.push_back(chk[8*(i-8) +: 8]);
            else frame_bytes.push_back(8'($urandom));
        end
        send_frame(oir_pkg::REQ_START);
    endtask

    // Data frame: header, seq, has-more, content, then the XOR-8 checksum
    // taken over the content bytes only.
    task automatic data_frame(input logic [15:0] s, input logic [7:0] more,
                              input int clen, input bit corrupt);
        logic [7:0] x;
        x = 0;
        frame_bytes.delete();
        repeat (4) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(s[7:0]);
        frame_bytes.push_back(s[15:8]);
        frame_bytes.push_back(more);
        for (int i = 0; i < clen; i++) begin
            frame_bytes.push_back(8'($urandom));
            x ^= frame_bytes[$];
        end
        frame_bytes.push_back(corrupt ? ~x : x);
        send_frame(oir_pkg::REQ_DATA);
    endtask

    task automatic retry_frame(input logic [1:0] rt, input logic [7:0] key, input int n);
        frame_bytes.delete();
        for (int i = 0; i < n; i++)
            frame_bytes.push_back(i == 4 ? key : 8'($urandom));
        send_frame(rt);
    endtask

    task automatic quiesce();
        while (pending_count != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == oir_pkg::CFG_FLAG) cur_flag = val;
    endtask

    // One download with mostly well-formed packets and some damage.
    task automatic random_session();
        int          len, sent, clen, np;
        logic [31:0] chk;
        len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(60) + 1;
        if (len > cur_flag) len = cur_flag;
        chk = ($urandom_range(3) == 0) ? $urandom : 32'h0;
        start_frame(len, chk, 12 + $urandom_range(2));
        send_seq = 0;
        sent = 0;
        np = 0;
        while (np < 12 && byte_count < byte_budget) begin
            clen = $urandom_range(oir_pkg::MaxContent);
            case ($urandom_range(19))
                0: data_frame(send_seq + 16'd1, 8'd1, clen, 1'b0);
                1: data_frame(send_seq, 8'd1, clen, 1'b1);
                2: retry_frame(oir_pkg::REQ_DATA, 8'($urandom), $urandom_range(9) + 1);
                3: retry_frame(oir_pkg::REQ_PKG, oir_pkg::KEY_PKG, 5 + $urandom_range(3));
                default: begin
                    sent += clen;
                    data_frame(send_seq, (sent >= len) ? 8'd0 : 8'($urandom_range(255, 1)),
                               clen, 1'b0);
                    send_seq++;
                    if (sent >= len) np = 100;
                end
            endcase
            np++;
        end
    endtask

    initial begin
        calm = 0;
        frame_count = 0;
        byte_count = 0;
        byte_budget = 0;
        cur_flag = 24'd65280;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part under reset settings.
        retry_frame(oir_pkg::REQ_ERASE, oir_pkg::KEY_ERASE, 5);
        retry_frame(oir_pkg::REQ_ERASE, 8'h00, 3);
        retry_frame(oir_pkg::REQ_PKG, 8'hFF, 5);
        start_frame(0, 0, 12);
        start_frame(32'h00FF01, 0, 12);
        start_frame(5, 0, 6);
        start_frame(4, 32'hFFFF_FFFF, 12);
        start_frame(7, 0, 12);
        data_frame(0, 1, 0, 0);
        data_frame(3, 1, 4, 0);
        data_frame(0, 1, 4, 1);
        data_frame(0, 1, 33, 0);
        data_frame(0, 8'hFF, oir_pkg::MaxContent, 0);
        retry_frame(oir_pkg::REQ_PKG, oir_pkg::KEY_PKG, 5);
        data_frame(0, 0, 3, 0);
        data_frame(0, 1, 2, 0);
        quiesce();

        write_reg(oir_pkg::CFG_FLAG, 24'hFFFFFF);
        write_reg(oir_pkg::CFG_BASE, 24'hFFFFF0);
        write_reg(oir_pkg::CFG_MAXR, 24'd1);
        write_reg(oir_pkg::CFG_MINF, 24'd8);
        start_frame(32'h00FFFFFF, 0, 12);
        retry_frame(oir_pkg::REQ_ERASE, oir_pkg::KEY_ERASE, 5);
        start_frame(40, 0, 12);
        data_frame(0, 1, 0, 0);
        data_frame(0, 1, 2, 1);
        quiesce();

        // Random sessions; the calm phase stalls on neither side, the last runs longest.
        for (int phase = 0; phase < 4; phase++) begin
            calm = (phase == 2);
            byte_budget = (phase == 0) ? 285 : (phase == 1) ? 315 :
                          (phase == 2) ? 385 : 415;
            write_reg(oir_pkg::CFG_FLAG,
                      (phase == 1) ? 24'd1 : 24'($urandom_range(24'hFFFFFF, 1)));
            write_reg(oir_pkg::CFG_BASE, 24'($urandom));
            write_reg(oir_pkg::CFG_MAXR,
                      (phase == 3) ? 24'd255 : 24'($urandom_range(6, 1)));
            write_reg(oir_pkg::CFG_MINF,
                      (phase == 0) ? 24'd40 : 24'($urandom_range(40, 8)));
            do
                random_session();
            while (byte_count < byte_budget);
            quiesce();
        end
        calm = 0;

        $display("Sent %0d frames (%0d bytes) and checked %0d results.",
                 frame_count, byte_count, result_count);
        $display("Covered start, data, retry frames and four register settings.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
